@@ hw/rtl/vrdc_pkg.sv @@
// Shared constants, types and helpers for the video resize dimension calculator.
`default_nettype none

package vrdc_pkg;

  // Largest legal frame dimension in pixels.
  localparam int MAX_DIMENSION = 8192;

  // Internal width of a dimension and of the quotient of the width division.
  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int QUO_W = DIM_W;

  // Port field widths.
  localparam int SRC_W     = 16;
  localparam int SAR_W     = 16;
  localparam int OUT_DIM_W = 14;
  localparam int TGT_W     = 14;
  localparam int STATUS_W  = 2;

  // Arithmetic widths of the width computation.
  localparam int PROD_W = 2 * DIM_W;
  localparam int DEN_W  = SAR_W + DIM_W;
  localparam int NUM_W  = PROD_W + SAR_W;
  localparam int REM_W  = NUM_W + 2;

  // Request queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_RESIZE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_UPSCALE = 2'd2;

  localparam logic                MODE_SOURCE = 1'b0;
  localparam logic [TGT_W-1:0]    TARGET_ROWS_RESET = 14'd1080;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SOURCE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_TARGET = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 2'd3;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic                needs_div;
    logic [STATUS_W-1:0] status;
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
    logic [DIM_W-1:0]    sh;
    logic [SAR_W-1:0]    sn;
    logic [SAR_W-1:0]    sd;
  } vrdc_job_t;

  // Fit an internal dimension into an output field.
  function automatic logic [OUT_DIM_W-1:0] fit_out(input logic [DIM_W:0] v);
    logic [DIM_W+OUT_DIM_W:0] t;
    t = {{OUT_DIM_W{1'b0}}, v};
    return t[OUT_DIM_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vrdc_front.sv @@
// Front end: configuration registers, source checks and output height choice.
`default_nettype none

module vrdc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [vrdc_pkg::SRC_W-1:0]   in_source_width,
  input  wire logic [vrdc_pkg::SRC_W-1:0]   in_source_height,
  input  wire logic [vrdc_pkg::SAR_W-1:0]   in_sar_numerator,
  input  wire logic [vrdc_pkg::SAR_W-1:0]   in_sar_denominator,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [vrdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vrdc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                              job_valid,
  input  wire logic                         job_ready,
  output vrdc_pkg::vrdc_job_t               job
);
  import vrdc_pkg::*;

  localparam logic [SRC_W-1:0] MAX_DIM_16 = SRC_W'(MAX_DIMENSION);

  logic              mode_r;
  logic [TGT_W-1:0]  target_r;
  logic              upscale_r;
  logic              fv_r;
  vrdc_job_t         job_r;
  vrdc_job_t         job_nxt;
  logic              accept;

  logic [SRC_W-1:0]  tgt16;
  logic [SRC_W-1:0]  tgt_even;
  logic [SRC_W-1:0]  h_cand;
  logic              src_bad;
  logic              tgt_bad;
  logic              h_bad;
  logic              sar_one;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_SOURCE;
      target_r  <= TARGET_ROWS_RESET;
      upscale_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RESIZE_MODE:   mode_r    <= cfg_data[0];
        CFG_TARGET_ROWS:   target_r  <= cfg_data[TGT_W-1:0];
        CFG_ALLOW_UPSCALE: upscale_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify the request and pick the output height.
  always_comb begin
    tgt16    = {{(SRC_W-TGT_W){1'b0}}, target_r};
    tgt_even = (tgt16 < 16'd2) ? 16'd2 : tgt16;
    if (tgt_even[0]) begin
      tgt_even = tgt_even + 16'd1;
    end
    src_bad = (in_source_width == '0) || (in_source_height == '0) ||
              (in_source_width > MAX_DIM_16) || (in_source_height > MAX_DIM_16);
    tgt_bad = (target_r == '0) || (tgt16 > MAX_DIM_16);
    if (!upscale_r && (in_source_height <= tgt16)) begin
      h_cand = {in_source_height[SRC_W-1:1], 1'b0};
    end else begin
      h_cand = tgt_even;
    end
    h_bad   = (h_cand == '0) || (h_cand > MAX_DIM_16);
    sar_one = (in_sar_numerator == '0) || (in_sar_denominator == '0);

    job_nxt = '0;
    if (src_bad) begin
      job_nxt.status = ST_BAD_SOURCE;
    end else if (mode_r == MODE_SOURCE) begin
      job_nxt.status = ST_OK;
      job_nxt.w      = in_source_width[DIM_W-1:0];
      job_nxt.h      = in_source_height[DIM_W-1:0];
      job_nxt.sn     = in_sar_numerator;
      job_nxt.sd     = in_sar_denominator;
    end else if (tgt_bad || h_bad) begin
      job_nxt.status = ST_BAD_TARGET;
    end else begin
      job_nxt.needs_div = 1'b1;
      job_nxt.status    = ST_OK;
      job_nxt.w         = in_source_width[DIM_W-1:0];
      job_nxt.h         = h_cand[DIM_W-1:0];
      job_nxt.sh        = in_source_height[DIM_W-1:0];
      job_nxt.sn        = sar_one ? SAR_W'(1) : in_sar_numerator;
      job_nxt.sd        = sar_one ? SAR_W'(1) : in_sar_denominator;
    end
  end

  // Front holding register, emptied into the queue.
  assign in_ready = !fv_r || job_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = fv_r;
  assign job       = job_r;

endmodule

`default_nettype wire

@@ hw/rtl/vrdc_queue.sv @@
// Short request queue between the front and the back.
`default_nettype none

module vrdc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire vrdc_pkg::vrdc_job_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output vrdc_pkg::vrdc_job_t pop_data
);
  import vrdc_pkg::*;

  vrdc_job_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vrdc_back.sv @@
// Back end: width products, pipelined rounding division and result register.
`default_nettype none

module vrdc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          job_valid,
  output logic                               job_ready,
  input  wire vrdc_pkg::vrdc_job_t           job,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [vrdc_pkg::STATUS_W-1:0]      out_status_code,
  output logic [vrdc_pkg::OUT_DIM_W-1:0]     out_width,
  output logic [vrdc_pkg::OUT_DIM_W-1:0]     out_height,
  output logic [vrdc_pkg::SAR_W-1:0]         out_sar_numerator,
  output logic [vrdc_pkg::SAR_W-1:0]         out_sar_denominator
);
  import vrdc_pkg::*;

  logic                 adv;

  // Product stages.
  logic                 s1_v_r;
  vrdc_job_t            s1_job_r;
  logic [PROD_W-1:0]    s1_hw_r;
  logic [DEN_W-1:0]     s1_den_r;
  logic                 s2_v_r;
  vrdc_job_t            s2_job_r;
  logic [NUM_W-1:0]     s2_num_r;
  logic [DEN_W-1:0]     s2_den_r;

  // Division stages; index 0 holds the prepared dividend and divisor.
  logic                 dv_r   [QUO_W+1];
  vrdc_job_t            djob_r [QUO_W+1];
  logic [REM_W-1:0]     drem_r [QUO_W+1];
  logic [DEN_W:0]       ddiv_r [QUO_W+1];
  logic [QUO_W-1:0]     dquo_r [QUO_W+1];
  logic                 dovf_r [QUO_W+1];

  logic [REM_W-1:0]     prep_n;
  logic [REM_W-1:0]     prep_d_top;
  logic [REM_W-1:0]     dsh_c  [QUO_W+1];
  logic [REM_W-1:0]     rem_c  [QUO_W+1];
  logic [QUO_W-1:0]     quo_c  [QUO_W+1];

  logic [DIM_W:0]       w_even;
  logic                 too_large;
  vrdc_job_t            fin_job;

  logic                 ov_r;
  logic [STATUS_W-1:0]  st_r;
  logic [OUT_DIM_W-1:0] ow_r;
  logic [OUT_DIM_W-1:0] oh_r;
  logic [SAR_W-1:0]     on_r;
  logic [SAR_W-1:0]     od_r;
  logic [STATUS_W-1:0]  st_nxt;
  logic [OUT_DIM_W-1:0] ow_nxt;
  logic [OUT_DIM_W-1:0] oh_nxt;
  logic [SAR_W-1:0]     on_nxt;
  logic [SAR_W-1:0]     od_nxt;

  // The whole back pipeline moves together when the result register can take.
  assign adv       = !ov_r || out_ready;
  assign job_ready = adv;

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      for (int k = 0; k <= QUO_W; k++) begin
        dv_r[k] <= 1'b0;
      end
      ov_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= job_valid;
      s2_v_r  <= s1_v_r;
      dv_r[0] <= s2_v_r;
      for (int k = 1; k <= QUO_W; k++) begin
        dv_r[k] <= dv_r[k-1];
      end
      ov_r <= dv_r[QUO_W];
    end
  end

  // Rounded division operands: (2*num + den) / (2*den), overflow if the
  // quotient does not fit the quotient width.
  always_comb begin
    prep_n     = {1'b0, s2_num_r, 1'b0} + {{(REM_W-DEN_W){1'b0}}, s2_den_r};
    prep_d_top = {{(REM_W-DEN_W-1){1'b0}}, s2_den_r, 1'b0} << QUO_W;
  end

  // One quotient bit per division stage, most significant first.
  always_comb begin
    dsh_c[0] = '0;
    rem_c[0] = '0;
    quo_c[0] = '0;
    for (int k = 1; k <= QUO_W; k++) begin
      dsh_c[k] = {{(REM_W-DEN_W-1){1'b0}}, ddiv_r[k-1]} << (QUO_W - k);
      if (drem_r[k-1] >= dsh_c[k]) begin
        rem_c[k] = drem_r[k-1] - dsh_c[k];
        quo_c[k] = dquo_r[k-1] | (QUO_W'(1) << (QUO_W - k));
      end else begin
        rem_c[k] = drem_r[k-1];
        quo_c[k] = dquo_r[k-1];
      end
    end
  end

  // Stage data registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_job_r  <= job;
      s1_hw_r   <= job.h * job.w;
      s1_den_r  <= job.sd * job.sh;
      s2_job_r  <= s1_job_r;
      s2_num_r  <= s1_hw_r * s1_job_r.sn;
      s2_den_r  <= s1_den_r;
      djob_r[0] <= s2_job_r;
      drem_r[0] <= prep_n;
      ddiv_r[0] <= {s2_den_r, 1'b0};
      dquo_r[0] <= '0;
      dovf_r[0] <= (prep_n >= prep_d_top);
      for (int k = 1; k <= QUO_W; k++) begin
        djob_r[k] <= djob_r[k-1];
        drem_r[k] <= rem_c[k];
        ddiv_r[k] <= ddiv_r[k-1];
        dquo_r[k] <= quo_c[k];
        dovf_r[k] <= dovf_r[k-1];
      end
    end
  end

  // Width to even, at least two, then range check and result assembly.
  always_comb begin
    fin_job = djob_r[QUO_W];
    w_even  = {1'b0, dquo_r[QUO_W]};
    if (w_even < (DIM_W+1)'(2)) begin
      w_even = (DIM_W+1)'(2);
    end
    if (w_even[0]) begin
      w_even = w_even + 1'b1;
    end
    too_large = dovf_r[QUO_W] || (32'(w_even) > 32'(MAX_DIMENSION));

    st_nxt = fin_job.status;
    ow_nxt = fit_out({1'b0, fin_job.w});
    oh_nxt = fit_out({1'b0, fin_job.h});
    on_nxt = fin_job.sn;
    od_nxt = fin_job.sd;
    if (fin_job.needs_div) begin
      if (too_large) begin
        st_nxt = ST_TOO_LARGE;
        ow_nxt = '0;
        oh_nxt = '0;
        on_nxt = '0;
        od_nxt = '0;
      end else begin
        st_nxt = ST_OK;
        ow_nxt = fit_out(w_even);
        on_nxt = SAR_W'(1);
        od_nxt = SAR_W'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
      ow_r <= ow_nxt;
      oh_r <= oh_nxt;
      on_r <= on_nxt;
      od_r <= od_nxt;
    end
  end

  assign out_valid           = ov_r;
  assign out_status_code     = st_r;
  assign out_width           = ow_r;
  assign out_height          = oh_r;
  assign out_sar_numerator   = on_r;
  assign out_sar_denominator = od_r;

endmodule

`default_nettype wire

@@ hw/rtl/video_resize_dimension_calc_unit.sv @@
// Top level of the video resize dimension calculator.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, source size and SAR  | request in
//   out     | out_valid/out_ready, status, size, SAR  | result out
//   cfg     | cfg_valid/cfg_ready, cfg_index/cfg_data | register write
//
// One request is taken per cycle while in_ready is high; each request gives one
// result through the front holding register, queue, two product stages, one
// operand stage, one stage per width quotient bit, and the result register.
// Reset is synchronous and active low; it restores the register defaults.
// A stalled result holds the back pipeline, while the front and queue keep
// taking requests until the queue is full.
`default_nettype none

module video_resize_dimension_calc_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [vrdc_pkg::SRC_W-1:0]      in_source_width,
  input  wire logic [vrdc_pkg::SRC_W-1:0]      in_source_height,
  input  wire logic [vrdc_pkg::SAR_W-1:0]      in_sar_numerator,
  input  wire logic [vrdc_pkg::SAR_W-1:0]      in_sar_denominator,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [vrdc_pkg::STATUS_W-1:0]        out_status_code,
  output logic [vrdc_pkg::OUT_DIM_W-1:0]       out_width,
  output logic [vrdc_pkg::OUT_DIM_W-1:0]       out_height,
  output logic [vrdc_pkg::SAR_W-1:0]           out_sar_numerator,
  output logic [vrdc_pkg::SAR_W-1:0]           out_sar_denominator,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [vrdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vrdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vrdc_pkg::*;

  logic      fq_valid;
  logic      fq_ready;
  vrdc_job_t fq_job;
  logic      qb_valid;
  logic      qb_ready;
  vrdc_job_t qb_job;

  // Front: checks and height choice.
  vrdc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_source_width    (in_source_width),
    .in_source_height   (in_source_height),
    .in_sar_numerator   (in_sar_numerator),
    .in_sar_denominator (in_sar_denominator),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .job_valid          (fq_valid),
    .job_ready          (fq_ready),
    .job                (fq_job)
  );

  // Queue between the two halves.
  vrdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  // Back: width computation and result.
  vrdc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_valid           (qb_valid),
    .job_ready           (qb_ready),
    .job                 (qb_job),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status_code     (out_status_code),
    .out_width           (out_width),
    .out_height          (out_height),
    .out_sar_numerator   (out_sar_numerator),
    .out_sar_denominator (out_sar_denominator)
  );

endmodule

`default_nettype wire
